// File: design/rgbc_pkg.sv
// Shared types, widths and codes of the RGBC color classifier.
package rgbc_pkg;

    // Sensor count width and fraction bits of the intensity format
    localparam int COUNT_BITS = 16;
    localparam int FRAC_BITS  = 16;

    // Intensity (0..1 inclusive) and sum of two intensities
    localparam int INT_W = FRAC_BITS + 1;
    localparam int SUM_W = FRAC_BITS + 2;

    // Pipelined restoring divider geometry
    localparam int DIV_QW = (COUNT_BITS > FRAC_BITS + 1) ? COUNT_BITS : FRAC_BITS + 1;
    localparam int DIV_DW = (FRAC_BITS + 1 > 16) ? FRAC_BITS + 1 : 16;
    localparam int DIV_NW = DIV_DW + DIV_QW;
    localparam int DIV_SIDE_W = 16 + 3 + SUM_W;

    // Square-root search: one result bit per stage, target is 10000 * S
    localparam int SQ_STEPS = 7;
    localparam int SQ_TW    = FRAC_BITS + 14;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 16;

    localparam logic [INT_W-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RANGE_LOW      = 3'd0,
        CFG_RANGE_HIGH     = 3'd1,
        CFG_GRAY_SAT_MAX   = 3'd2,
        CFG_BLACK_LIT_MAX  = 3'd3,
        CFG_WHITE_LIT_MIN  = 3'd4
    } t_cfg_idx;

    // Color class codes
    localparam logic [2:0] CLASS_WHITE  = 3'd0;
    localparam logic [2:0] CLASS_BLACK  = 3'd1;
    localparam logic [2:0] CLASS_GRAY   = 3'd2;
    localparam logic [2:0] CLASS_RED    = 3'd3;
    localparam logic [2:0] CLASS_YELLOW = 3'd4;
    localparam logic [2:0] CLASS_GREEN  = 3'd5;
    localparam logic [2:0] CLASS_BLUE   = 3'd6;
    localparam logic [2:0] CLASS_NONE   = 3'd7;

    // Hue sector base angle
    typedef enum logic [1:0] {
        BASE_0,
        BASE_120,
        BASE_240,
        BASE_360
    } t_hue_base;

    typedef struct packed {
        logic [15:0] red_count;
        logic [15:0] green_count;
        logic [15:0] blue_count;
        logic [15:0] clear_count;
    } t_in_item;

    typedef struct packed {
        logic [8:0]  hue_degrees;
        logic [6:0]  saturation_pct;
        logic [6:0]  lightness_pct;
        logic [15:0] clear_echo;
        logic [2:0]  color_class;
    } t_out_item;

    // Sideband carried alongside the hue divider
    typedef struct packed {
        logic [15:0]      clear;
        t_hue_base        base;
        logic             neg;
        logic [SUM_W-1:0] sum;
    } t_side_c;

    // Sideband carried alongside the square-root search
    typedef struct packed {
        logic [8:0]  hue;
        logic [6:0]  lit;
        logic [15:0] clear;
    } t_sq_side;

endpackage

// File: design/rgbc_divider.sv
// Pipelined restoring divider, one quotient bit per stage, with sideband.
module rgbc_divider (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_en,
    input  logic                            i_valid,
    input  logic [rgbc_pkg::DIV_NW-1:0]     i_num,
    input  logic [rgbc_pkg::DIV_DW-1:0]     i_den,
    input  logic [rgbc_pkg::DIV_SIDE_W-1:0] i_side,
    output logic                            o_valid,
    output logic [rgbc_pkg::DIV_QW-1:0]     o_quo,
    output logic [rgbc_pkg::DIV_SIDE_W-1:0] o_side
);
    import rgbc_pkg::*;

    // Upper numerator half must be below the divisor on entry
    logic                  r_valid [DIV_QW];
    logic [DIV_DW-1:0]     r_rem   [DIV_QW];
    logic [DIV_DW-1:0]     r_den   [DIV_QW];
    logic [DIV_QW-1:0]     r_low   [DIV_QW];
    logic [DIV_QW-1:0]     r_quo   [DIV_QW];
    logic [DIV_SIDE_W-1:0] r_side  [DIV_QW];

    logic                  n_valid [DIV_QW];
    logic [DIV_DW-1:0]     n_rem   [DIV_QW];
    logic [DIV_DW-1:0]     n_den   [DIV_QW];
    logic [DIV_QW-1:0]     n_low   [DIV_QW];
    logic [DIV_QW-1:0]     n_quo   [DIV_QW];
    logic [DIV_SIDE_W-1:0] n_side  [DIV_QW];

    // One compare and subtract per stage
    always_comb begin
        logic [DIV_DW-1:0] rem_in;
        logic [DIV_DW-1:0] den_in;
        logic [DIV_QW-1:0] low_in;
        logic [DIV_QW-1:0] quo_in;
        logic [DIV_DW:0]   trial;
        logic              ge;
        for (int j = 0; j < DIV_QW; j++) begin
            if (j == 0) begin
                rem_in    = i_num[DIV_NW-1:DIV_QW];
                low_in    = i_num[DIV_QW-1:0];
                quo_in    = '0;
                den_in    = i_den;
                n_valid[j] = i_valid;
                n_side[j]  = i_side;
            end else begin
                rem_in    = r_rem[j-1];
                low_in    = r_low[j-1];
                quo_in    = r_quo[j-1];
                den_in    = r_den[j-1];
                n_valid[j] = r_valid[j-1];
                n_side[j]  = r_side[j-1];
            end
            trial = {rem_in, low_in[DIV_QW-1]};
            ge    = (trial >= {1'b0, den_in});
            if (ge) begin
                n_rem[j] = DIV_DW'(trial - {1'b0, den_in});
            end else begin
                n_rem[j] = trial[DIV_DW-1:0];
            end
            n_low[j] = low_in << 1;
            n_quo[j] = {quo_in[DIV_QW-2:0], ge};
            n_den[j] = den_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < DIV_QW; j++) r_valid[j] <= 1'b0;
        end else if (i_en) begin
            for (int j = 0; j < DIV_QW; j++) r_valid[j] <= n_valid[j];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int j = 0; j < DIV_QW; j++) begin
                r_rem[j]  <= n_rem[j];
                r_den[j]  <= n_den[j];
                r_low[j]  <= n_low[j];
                r_quo[j]  <= n_quo[j];
                r_side[j] <= n_side[j];
            end
        end
    end

    assign o_valid = r_valid[DIV_QW-1];
    assign o_quo   = r_quo[DIV_QW-1];
    assign o_side  = r_side[DIV_QW-1];

endmodule

// File: design/rgbc_sqrt.sv
// Pipelined bitwise search for floor(100 * sqrt(S)), one bit per stage.
module rgbc_sqrt (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_valid,
    input  logic [rgbc_pkg::SQ_TW-1:0] i_target,
    input  rgbc_pkg::t_sq_side         i_side,
    output logic                       o_valid,
    output logic [6:0]                 o_sat,
    output rgbc_pkg::t_sq_side         o_side
);
    import rgbc_pkg::*;

    logic             r_valid [SQ_STEPS];
    logic [6:0]       r_sat   [SQ_STEPS];
    logic [SQ_TW-1:0] r_tgt   [SQ_STEPS];
    t_sq_side         r_side  [SQ_STEPS];

    logic             n_valid [SQ_STEPS];
    logic [6:0]       n_sat   [SQ_STEPS];
    logic [SQ_TW-1:0] n_tgt   [SQ_STEPS];
    t_sq_side         n_side  [SQ_STEPS];

    // Try setting the next lower bit; keep it if t <= 100 and t*t*2^F <= target
    always_comb begin
        logic [6:0]       sat_in;
        logic [SQ_TW-1:0] tgt_in;
        logic [6:0]       t;
        logic [13:0]      sq;
        for (int j = 0; j < SQ_STEPS; j++) begin
            if (j == 0) begin
                sat_in     = '0;
                tgt_in     = i_target;
                n_valid[j] = i_valid;
                n_side[j]  = i_side;
            end else begin
                sat_in     = r_sat[j-1];
                tgt_in     = r_tgt[j-1];
                n_valid[j] = r_valid[j-1];
                n_side[j]  = r_side[j-1];
            end
            t  = sat_in | (7'd1 << (SQ_STEPS - 1 - j));
            sq = 14'(t) * 14'(t);
            if (t <= 7'd100 && ((SQ_TW'(sq) << FRAC_BITS) <= tgt_in)) begin
                n_sat[j] = t;
            end else begin
                n_sat[j] = sat_in;
            end
            n_tgt[j] = tgt_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < SQ_STEPS; j++) r_valid[j] <= 1'b0;
        end else if (i_en) begin
            for (int j = 0; j < SQ_STEPS; j++) r_valid[j] <= n_valid[j];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int j = 0; j < SQ_STEPS; j++) begin
                r_sat[j]  <= n_sat[j];
                r_tgt[j]  <= n_tgt[j];
                r_side[j] <= n_side[j];
            end
        end
    end

    assign o_valid = r_valid[SQ_STEPS-1];
    assign o_sat   = r_sat[SQ_STEPS-1];
    assign o_side  = r_side[SQ_STEPS-1];

endmodule

// File: design/rgbc_color_classifier_top.sv
// Top level of the RGBC color classifier: count scaling, intensity, HSL and class.
// One reading enters and one result leaves per cycle unless the output stalls. The
// path runs through three pipelined dividers of one quotient bit per stage (scaling,
// intensity, hue/saturation) and the seven-stage square-root search. The whole
// pipeline advances together when the output register is empty or taken, so
// o_in_ready follows i_out_ready in the same cycle. Configuration may be written
// only while the pipeline is empty.
module rgbc_color_classifier_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  rgbc_pkg::t_in_item               i_in_data,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output rgbc_pkg::t_out_item              o_out_data,
    input  logic                             i_cfg_wr_en,
    input  logic [rgbc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [rgbc_pkg::CFG_W-1:0]       i_cfg_wdata
);
    import rgbc_pkg::*;

    typedef enum logic [1:0] {
        MAX_RED,
        MAX_GREEN,
        MAX_BLUE
    } t_max_sel;

    localparam int SC_W  = 2 * COUNT_BITS + 8;
    localparam int LIT_W = SUM_W + 7;
    localparam logic [8:0] HUE_RED_HI    = 9'd345;
    localparam logic [8:0] HUE_RED_LO    = 9'd45;
    localparam logic [8:0] HUE_YELLOW_HI = 9'd90;
    localparam logic [8:0] HUE_GREEN_LO  = 9'd120;
    localparam logic [8:0] HUE_GREEN_HI  = 9'd150;
    localparam logic [8:0] HUE_BLUE_HI   = 9'd190;

    logic adv;

    // Configuration registers
    logic [15:0] r_range_low;
    logic [15:0] r_range_high;
    logic [6:0]  r_gray_sat_max;
    logic [6:0]  r_black_lit_max;
    logic [6:0]  r_white_lit_min;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_range_low     <= 16'd15;
            r_range_high    <= 16'd165;
            r_gray_sat_max  <= 7'd15;
            r_black_lit_max <= 7'd35;
            r_white_lit_min <= 7'd85;
        end else if (i_cfg_wr_en) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_RANGE_LOW:     r_range_low     <= i_cfg_wdata;
                CFG_RANGE_HIGH:    r_range_high    <= i_cfg_wdata;
                CFG_GRAY_SAT_MAX:  r_gray_sat_max  <= i_cfg_wdata[6:0];
                CFG_BLACK_LIT_MAX: r_black_lit_max <= i_cfg_wdata[6:0];
                CFG_WHITE_LIT_MIN: r_white_lit_min <= i_cfg_wdata[6:0];
                default: ;
            endcase
        end
    end

    // Whole pipeline moves when the output register is free
    assign adv        = !o_out_valid || i_out_ready;
    assign o_in_ready = adv;

    // ---------------- Stage 1: scaling setup ----------------
    logic [COUNT_BITS-1:0] cnt [3];
    logic [COUNT_BITS-1:0] clr;
    logic                  sat_flag [3];
    logic [DIV_NW-1:0]     n1_num [3];
    logic [DIV_DW-1:0]     n1_den;

    logic                  r1_valid;
    logic [DIV_NW-1:0]     r1_num [3];
    logic [DIV_DW-1:0]     r1_den;
    logic [DIV_SIDE_W-1:0] r1_side;

    always_comb begin
        cnt[0] = i_in_data.red_count[COUNT_BITS-1:0];
        cnt[1] = i_in_data.green_count[COUNT_BITS-1:0];
        cnt[2] = i_in_data.blue_count[COUNT_BITS-1:0];
        clr    = i_in_data.clear_count[COUNT_BITS-1:0];
        n1_den = (clr == '0) ? DIV_DW'(1) : DIV_DW'(clr);
        for (int k = 0; k < 3; k++) begin
            // 256*c/clr overflows exactly when c*256 >= clr * 2^COUNT_BITS
            sat_flag[k] = (clr != '0) &&
                          ((SC_W'(cnt[k]) << 8) >= (SC_W'(clr) << COUNT_BITS));
            if (clr == '0 || sat_flag[k]) begin
                n1_num[k] = '0;
            end else begin
                n1_num[k] = DIV_NW'(cnt[k]) << 8;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (adv) begin
            r1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r1_num  <= n1_num;
            r1_den  <= n1_den;
            r1_side <= DIV_SIDE_W'({sat_flag[0], sat_flag[1], sat_flag[2],
                                    i_in_data.clear_count});
        end
    end

    // ---------------- Scaling dividers ----------------
    logic                  va;
    logic [DIV_QW-1:0]     qa [3];
    logic [DIV_SIDE_W-1:0] side_a;

    rgbc_divider u_div_scale_r (
        .i_clk, .i_rst_n, .i_en(adv), .i_valid(r1_valid),
        .i_num(r1_num[0]), .i_den(r1_den), .i_side(r1_side),
        .o_valid(va), .o_quo(qa[0]), .o_side(side_a)
    );
    rgbc_divider u_div_scale_g (
        .i_clk, .i_rst_n, .i_en(adv), .i_valid(r1_valid),
        .i_num(r1_num[1]), .i_den(r1_den), .i_side('0),
        .o_valid(), .o_quo(qa[1]), .o_side()
    );
    rgbc_divider u_div_scale_b (
        .i_clk, .i_rst_n, .i_en(adv), .i_valid(r1_valid),
        .i_num(r1_num[2]), .i_den(r1_den), .i_side('0),
        .o_valid(), .o_quo(qa[2]), .o_side()
    );

    // ---------------- Stage 2: intensity setup ----------------
    logic [15:0]           vsc [3];
    logic                  lo_flag [3];
    logic                  hi_flag [3];
    logic                  bad_range;
    logic [DIV_NW-1:0]     n2_num [3];
    logic [DIV_DW-1:0]     n2_den;

    logic                  r2_valid;
    logic [DIV_NW-1:0]     r2_num [3];
    logic [DIV_DW-1:0]     r2_den;
    logic [DIV_SIDE_W-1:0] r2_side;

    always_comb begin
        bad_range = (r_range_high <= r_range_low);
        n2_den    = bad_range ? DIV_DW'(1) : DIV_DW'(r_range_high - r_range_low);
        for (int k = 0; k < 3; k++) begin
            if (side_a[18 - k]) begin
                vsc[k] = 16'(COUNT_MAX);
            end else begin
                vsc[k] = 16'(qa[k][COUNT_BITS-1:0]);
            end
            lo_flag[k] = bad_range || (vsc[k] <= r_range_low);
            hi_flag[k] = !lo_flag[k] && (vsc[k] >= r_range_high);
            if (lo_flag[k] || hi_flag[k]) begin
                n2_num[k] = '0;
            end else begin
                n2_num[k] = DIV_NW'(vsc[k] - r_range_low) << FRAC_BITS;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (adv) begin
            r2_valid <= va;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r2_num  <= n2_num;
            r2_den  <= n2_den;
            r2_side <= DIV_SIDE_W'({hi_flag[0], hi_flag[1], hi_flag[2], side_a[15:0]});
        end
    end

    // ---------------- Intensity dividers ----------------
    logic                  vb;
    logic [DIV_QW-1:0]     qb [3];
    logic [DIV_SIDE_W-1:0] side_b;

    rgbc_divider u_div_int_r (
        .i_clk, .i_rst_n, .i_en(adv), .i_valid(r2_valid),
        .i_num(r2_num[0]), .i_den(r2_den), .i_side(r2_side),
        .o_valid(vb), .o_quo(qb[0]), .o_side(side_b)
    );
    rgbc_divider u_div_int_g (
        .i_clk, .i_rst_n, .i_en(adv), .i_valid(r2_valid),
        .i_num(r2_num[1]), .i_den(r2_den), .i_side('0),
        .o_valid(), .o_quo(qb[1]), .o_side()
    );
    rgbc_divider u_div_int_b (
        .i_clk, .i_rst_n, .i_en(adv), .i_valid(r2_valid),
        .i_num(r2_num[2]), .i_den(r2_den), .i_side('0),
        .o_valid(), .o_quo(qb[2]), .o_side()
    );

    // ---------------- Stage 3: intensities ----------------
    logic             r3_valid;
    logic [INT_W-1:0] r3_int [3];
    logic [15:0]      r3_clear;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else if (adv) begin
            r3_valid <= vb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int k = 0; k < 3; k++) begin
                r3_int[k] <= side_b[18 - k] ? ONE : qb[k][INT_W-1:0];
            end
            r3_clear <= side_b[15:0];
        end
    end

    // ---------------- Stage 4: max and min ----------------
    t_max_sel         n4_sel;
    logic [INT_W-1:0] n4_mx;
    logic [INT_W-1:0] n4_mn;

    logic             r4_valid;
    logic [INT_W-1:0] r4_int [3];
    logic [INT_W-1:0] r4_mx;
    logic [INT_W-1:0] r4_mn;
    t_max_sel         r4_sel;
    logic [15:0]      r4_clear;

    // Ties go to red, then green
    always_comb begin
        if (r3_int[0] >= r3_int[1] && r3_int[0] >= r3_int[2]) begin
            n4_sel = MAX_RED;
            n4_mx  = r3_int[0];
        end else if (r3_int[1] >= r3_int[2]) begin
            n4_sel = MAX_GREEN;
            n4_mx  = r3_int[1];
        end else begin
            n4_sel = MAX_BLUE;
            n4_mx  = r3_int[2];
        end
        n4_mn = r3_int[0];
        if (r3_int[1] < n4_mn) n4_mn = r3_int[1];
        if (r3_int[2] < n4_mn) n4_mn = r3_int[2];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_valid <= 1'b0;
        end else if (adv) begin
            r4_valid <= r3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r4_int   <= r3_int;
            r4_mx    <= n4_mx;
            r4_mn    <= n4_mn;
            r4_sel   <= n4_sel;
            r4_clear <= r3_clear;
        end
    end

    // ---------------- Stage 5: hue and saturation setup ----------------
    logic [INT_W-1:0]  delta;
    logic [SUM_W-1:0]  sum;
    logic [SUM_W-1:0]  den_full;
    logic [INT_W-1:0]  op_a;
    logic [INT_W-1:0]  op_b;
    logic [INT_W-1:0]  diff;
    t_side_c           n5_side;
    logic [DIV_NW-1:0] n5_hnum;
    logic [DIV_DW-1:0] n5_hden;
    logic [DIV_NW-1:0] n5_snum;
    logic [DIV_DW-1:0] n5_sden;

    logic              r5_valid;
    logic [DIV_NW-1:0] r5_hnum;
    logic [DIV_DW-1:0] r5_hden;
    logic [DIV_NW-1:0] r5_snum;
    logic [DIV_DW-1:0] r5_sden;
    t_side_c           r5_side;

    always_comb begin
        delta    = r4_mx - r4_mn;
        sum      = SUM_W'(r4_mx) + SUM_W'(r4_mn);
        den_full = (sum <= SUM_W'(ONE)) ? sum : ((SUM_W'(ONE) << 1) - sum);
        n5_side.clear = r4_clear;
        n5_side.sum   = sum;
        case (r4_sel)
            MAX_RED: begin
                op_a = r4_int[1];
                op_b = r4_int[2];
            end
            MAX_GREEN: begin
                op_a = r4_int[2];
                op_b = r4_int[0];
            end
            default: begin
                op_a = r4_int[0];
                op_b = r4_int[1];
            end
        endcase
        n5_side.neg = (op_a < op_b);
        diff = n5_side.neg ? (op_b - op_a) : (op_a - op_b);
        case (r4_sel)
            MAX_RED:   n5_side.base = n5_side.neg ? BASE_360 : BASE_0;
            MAX_GREEN: n5_side.base = BASE_120;
            default:   n5_side.base = BASE_240;
        endcase
        // Negative side rounds up: add delta-1 before the floor division
        n5_hnum = DIV_NW'(diff) * DIV_NW'(60);
        if (n5_side.neg) n5_hnum = n5_hnum + DIV_NW'(delta) - DIV_NW'(1);
        n5_hden = DIV_DW'(delta);
        if (delta == '0) begin
            n5_side.base = BASE_0;
            n5_side.neg  = 1'b0;
            n5_hnum      = '0;
            n5_hden      = DIV_DW'(1);
        end
        // Saturation = delta / (1 - |2L - 1|)
        if (delta == '0 || den_full == '0) begin
            n5_snum = '0;
            n5_sden = DIV_DW'(1);
        end else begin
            n5_snum = DIV_NW'(delta) << FRAC_BITS;
            n5_sden = DIV_DW'(den_full);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_valid <= 1'b0;
        end else if (adv) begin
            r5_valid <= r4_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r5_hnum <= n5_hnum;
            r5_hden <= n5_hden;
            r5_snum <= n5_snum;
            r5_sden <= n5_sden;
            r5_side <= n5_side;
        end
    end

    // ---------------- Hue and saturation dividers ----------------
    logic                  vc;
    logic [DIV_QW-1:0]     qh;
    logic [DIV_QW-1:0]     qs;
    logic [DIV_SIDE_W-1:0] side_c_vec;

    rgbc_divider u_div_hue (
        .i_clk, .i_rst_n, .i_en(adv), .i_valid(r5_valid),
        .i_num(r5_hnum), .i_den(r5_hden), .i_side(DIV_SIDE_W'(r5_side)),
        .o_valid(vc), .o_quo(qh), .o_side(side_c_vec)
    );
    rgbc_divider u_div_sat (
        .i_clk, .i_rst_n, .i_en(adv), .i_valid(r5_valid),
        .i_num(r5_snum), .i_den(r5_sden), .i_side('0),
        .o_valid(), .o_quo(qs), .o_side()
    );

    // ---------------- Stage 6: hue, lightness, root target ----------------
    t_side_c          side_c;
    logic [8:0]       base_deg;
    logic [INT_W-1:0] pre;
    logic [LIT_W-1:0] lit_prod;
    t_sq_side         n6_side;

    logic             r6_valid;
    logic [SQ_TW-1:0] r6_target;
    t_sq_side         r6_side;

    always_comb begin
        side_c = t_side_c'(side_c_vec);
        case (side_c.base)
            BASE_0:   base_deg = 9'd0;
            BASE_120: base_deg = 9'd120;
            BASE_240: base_deg = 9'd240;
            default:  base_deg = 9'd360;
        endcase
        n6_side.hue = side_c.neg ? (base_deg - qh[8:0]) : (base_deg + qh[8:0]);
        pre = (qs > DIV_QW'(ONE)) ? ONE : qs[INT_W-1:0];
        lit_prod = LIT_W'(side_c.sum) * LIT_W'(100);
        n6_side.lit   = 7'(lit_prod >> (FRAC_BITS + 1));
        n6_side.clear = side_c.clear;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_valid <= 1'b0;
        end else if (adv) begin
            r6_valid <= vc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r6_target <= SQ_TW'(pre) * SQ_TW'(10000);
            r6_side   <= n6_side;
        end
    end

    // ---------------- Square-root search ----------------
    logic       vd;
    logic [6:0] sat_pct;
    t_sq_side   side_d;

    rgbc_sqrt u_sqrt (
        .i_clk, .i_rst_n, .i_en(adv), .i_valid(r6_valid),
        .i_target(r6_target), .i_side(r6_side),
        .o_valid(vd), .o_sat(sat_pct), .o_side(side_d)
    );

    // ---------------- Output stage: classification ----------------
    logic [2:0] n_class;
    logic       r_out_valid;
    t_out_item  r_out_data;

    always_comb begin
        if (sat_pct <= r_gray_sat_max || side_d.lit <= r_black_lit_max ||
            side_d.lit >= r_white_lit_min) begin
            if (side_d.lit >= r_white_lit_min) begin
                n_class = CLASS_WHITE;
            end else if (side_d.lit <= r_black_lit_max) begin
                n_class = CLASS_BLACK;
            end else begin
                n_class = CLASS_GRAY;
            end
        end else if (side_d.hue >= HUE_RED_HI || side_d.hue < HUE_RED_LO) begin
            n_class = CLASS_RED;
        end else if (side_d.hue < HUE_YELLOW_HI) begin
            n_class = CLASS_YELLOW;
        end else if (side_d.hue >= HUE_GREEN_LO && side_d.hue < HUE_GREEN_HI) begin
            n_class = CLASS_GREEN;
        end else if (side_d.hue >= HUE_GREEN_HI && side_d.hue < HUE_BLUE_HI) begin
            n_class = CLASS_BLUE;
        end else begin
            n_class = CLASS_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= vd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_data.hue_degrees    <= side_d.hue;
            r_out_data.saturation_pct <= sat_pct;
            r_out_data.lightness_pct  <= side_d.lit;
            r_out_data.clear_echo     <= side_d.clear;
            r_out_data.color_class    <= n_class;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// File: design/rgbc_checker.sv
// Port-level checker for the RGBC color classifier, bound to the top level.
module rgbc_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           o_in_ready,
    input logic                           o_out_valid,
    input logic                           i_out_ready,
    input rgbc_pkg::t_out_item            o_out_data
);

    // A stalled item holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result item changed while stalled");

    // Empty output register never blocks the input side
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty output");

    // Reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result present right after reset");

    // Result fields stay in range
    a_ranges: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.hue_degrees < 9'd360 &&
                        o_out_data.saturation_pct <= 7'd100 &&
                        o_out_data.lightness_pct <= 7'd100)
        else $error("result field out of range");

endmodule

bind rgbc_color_classifier_top rgbc_checker u_rgbc_checker (.*);

// File: test/rgbc_color_classifier_checker.sv
// Result checker for the RGBC color classifier: predicts each reading and compares.
`timescale 1ns / 100ps

module rgbc_color_classifier_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           i_in_ready,
    input  rgbc_pkg::t_in_item             i_in_data,
    input  logic                           i_out_valid,
    input  logic                           i_out_ready,
    input  rgbc_pkg::t_out_item            i_out_data,
    input  logic                           i_cfg_wr_en,
    input  logic [rgbc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [rgbc_pkg::CFG_W-1:0]     i_cfg_wdata,
    output int                             o_fail_count,
    output int                             o_pending
);
    import rgbc_pkg::*;

    localparam longint unsigned UNIT = 64'd1 << FRAC_BITS;
    localparam longint unsigned CMAX = (64'd1 << COUNT_BITS) - 1;

    // Shadow copy of the configuration registers
    longint unsigned lo_bound, hi_bound, gray_sat, black_lit, white_lit;

    t_out_item expected_results[$];

    assign o_pending = expected_results.size();

    function automatic longint unsigned scaled_count(longint unsigned c, longint unsigned clr);
        longint unsigned v;
        if (clr == 0) return 0;
        v = (c * 256) / clr;
        return (v > CMAX) ? CMAX : v;
    endfunction

    function automatic longint unsigned to_intensity(longint unsigned v);
        if (hi_bound <= lo_bound) return 0;
        if (v <= lo_bound) return 0;
        if (v >= hi_bound) return UNIT;
        return ((v - lo_bound) << FRAC_BITS) / (hi_bound - lo_bound);
    endfunction

    // base + 60*(a-b)/d rounded toward minus infinity
    function automatic longint unsigned hue_from(longint unsigned base, longint unsigned a,
                                                 longint unsigned b, longint unsigned d);
        if (a >= b) return base + (60 * (a - b)) / d;
        return base - (60 * (b - a) + d - 1) / d;
    endfunction

    function automatic t_out_item classify(t_in_item rd);
        longint unsigned clr, r, g, b, mx, mn, delta, sum, den, pre, hue, sat, lit, t;
        logic [2:0] cls;
        t_out_item res;
        clr = rd.clear_count & CMAX;
        r = to_intensity(scaled_count(rd.red_count & CMAX, clr));
        g = to_intensity(scaled_count(rd.green_count & CMAX, clr));
        b = to_intensity(scaled_count(rd.blue_count & CMAX, clr));
        mx = r; mn = r; hue = 0; sat = 0;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        delta = mx - mn;
        sum = mx + mn;
        if (delta != 0) begin
            if (mx == r) hue = (g >= b) ? hue_from(0, g, b, delta) : hue_from(360, g, b, delta);
            else if (mx == g) hue = hue_from(120, b, r, delta);
            else hue = hue_from(240, r, g, delta);
            den = (sum <= UNIT) ? sum : (2 * UNIT - sum);
            if (den != 0) begin
                pre = (delta << FRAC_BITS) / den;
                if (pre > UNIT) pre = UNIT;
                for (int k = 6; k >= 0; k--) begin
                    t = sat | (64'd1 << k);
                    if (t <= 100 && ((t * t) << FRAC_BITS) <= 10000 * pre) sat = t;
                end
            end
        end
        lit = (100 * sum) >> (FRAC_BITS + 1);
        if (sat <= gray_sat || lit <= black_lit || lit >= white_lit) begin
            if (lit >= white_lit) cls = CLASS_WHITE;
            else if (lit <= black_lit) cls = CLASS_BLACK;
            else cls = CLASS_GRAY;
        end else begin
            if (hue >= 345 || hue < 45) cls = CLASS_RED;
            else if (hue < 90) cls = CLASS_YELLOW;
            else if (hue >= 120 && hue < 150) cls = CLASS_GREEN;
            else if (hue >= 150 && hue < 190) cls = CLASS_BLUE;
            else cls = CLASS_NONE;
        end
        res.hue_degrees = hue[8:0];
        res.saturation_pct = sat[6:0];
        res.lightness_pct = lit[6:0];
        res.clear_echo = rd.clear_count;
        res.color_class = cls;
        return res;
    endfunction

    task automatic compare_field(string name, longint unsigned exp_v, longint unsigned act_v);
        if (exp_v != act_v) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, exp_v, act_v);
            o_fail_count = o_fail_count + 1;
        end
    endtask

    // Track config, predict accepted readings and check accepted results
    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            lo_bound <= 15; hi_bound <= 165; gray_sat <= 15; black_lit <= 35; white_lit <= 85;
            o_fail_count = 0;
            expected_results.delete();
        end else begin
            if (i_cfg_wr_en) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_RANGE_LOW:     lo_bound  <= i_cfg_wdata;
                    CFG_RANGE_HIGH:    hi_bound  <= i_cfg_wdata;
                    CFG_GRAY_SAT_MAX:  gray_sat  <= i_cfg_wdata[6:0];
                    CFG_BLACK_LIT_MAX: black_lit <= i_cfg_wdata[6:0];
                    CFG_WHITE_LIT_MIN: white_lit <= i_cfg_wdata[6:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) expected_results.push_back(classify(i_in_data));
            if (i_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result: expected none, actual %h",
                             $time, i_out_data);
                    o_fail_count = o_fail_count + 1;
                end else begin
                    want = expected_results.pop_front();
                    compare_field("hue", want.hue_degrees, i_out_data.hue_degrees);
                    compare_field("saturation", want.saturation_pct, i_out_data.saturation_pct);
                    compare_field("lightness", want.lightness_pct, i_out_data.lightness_pct);
                    compare_field("clear", want.clear_echo, i_out_data.clear_echo);
                    compare_field("class", want.color_class, i_out_data.color_class);
                end
            end
        end
    end

endmodule

// File: test/tb_rgbc_color_classifier_top.sv
// Testbench top of the RGBC color classifier: stimulus, config phases and verdict.
`timescale 1ns / 100ps

module tb_rgbc_color_classifier_top;
    import rgbc_pkg::*;

    localparam int LATENCY = 3 * DIV_QW + SQ_STEPS + 7;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    t_in_item             in_data = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    t_out_item            out_data;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_wdata = '0;
    int                   fail_count;
    int                   pending;
    bit                   quiet_tail = 1'b0;
    bit                   long_hold = 1'b0;

    always #1 clk = ~clk;

    rgbc_color_classifier_top u_dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_ready(in_ready), .i_in_data(in_data),
        .o_out_valid(out_valid), .i_out_ready(out_ready), .o_out_data(out_data),
        .i_cfg_wr_en(cfg_wr_en), .i_cfg_index(cfg_index), .i_cfg_wdata(cfg_wdata)
    );

    rgbc_color_classifier_checker u_checker (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .i_in_ready(in_ready), .i_in_data(in_data),
        .i_out_valid(out_valid), .i_out_ready(out_ready), .i_out_data(out_data),
        .i_cfg_wr_en(cfg_wr_en), .i_cfg_index(cfg_index), .i_cfg_wdata(cfg_wdata),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // Receiver: random stall bursts, one long hold-off on request
    initial begin
        int n;
        @(posedge clk iff rst_n);
        forever begin
            if (long_hold) begin
                out_ready <= 1'b0;
                repeat (300) @(posedge clk);
                long_hold = 1'b0;
            end else if (!quiet_tail && $urandom_range(0, 3) == 0) begin
                out_ready <= 1'b0;
                n = $urandom_range(1, 10);
                repeat (n) @(posedge clk);
            end else begin
                out_ready <= 1'b1;
                n = $urandom_range(1, 20);
                repeat (n) @(posedge clk);
            end
        end
    end

    task automatic send_reading(t_in_item rd);
        int gap;
        if (!quiet_tail && $urandom_range(0, 5) == 0) begin
            in_valid <= 1'b0;
            gap = $urandom_range(1, 10);
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= rd;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    task automatic drain_pipeline();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (LATENCY + 5) @(posedge clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [CFG_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic set_config(int lo, int hi, int gs, int bl, int wl);
        write_reg(CFG_RANGE_LOW, CFG_W'(lo));
        write_reg(CFG_RANGE_HIGH, CFG_W'(hi));
        write_reg(CFG_GRAY_SAT_MAX, CFG_W'(gs));
        write_reg(CFG_BLACK_LIT_MAX, CFG_W'(bl));
        write_reg(CFG_WHITE_LIT_MIN, CFG_W'(wl));
    endtask

    function automatic t_in_item make_reading(int r, int g, int b, int c);
        t_in_item rd;
        rd.red_count = 16'(r); rd.green_count = 16'(g);
        rd.blue_count = 16'(b); rd.clear_count = 16'(c);
        return rd;
    endfunction

    // Mostly clear-relative colors that land inside the bounds, some full-range noise
    function automatic t_in_item random_reading(int hi);
        t_in_item rd;
        int c, lim;
        if ($urandom_range(0, 4) == 0) begin
            rd = {$urandom, $urandom};
        end else begin
            c = $urandom_range(1, 4000);
            lim = (c * hi) / 256 + 2;
            if (lim > 65535) lim = 65535;
            rd = make_reading($urandom_range(0, lim), $urandom_range(0, lim),
                              $urandom_range(0, lim), c);
        end
        return rd;
    endfunction

    task automatic random_phase(int count, int hi);
        repeat (count) send_reading(random_reading(hi));
    endtask

    // Limit
    initial begin
        #2000000;
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extremes and special cases at reset bounds
        send_reading(make_reading(0, 0, 0, 0));
        send_reading(make_reading(65535, 65535, 65535, 0));
        send_reading(make_reading(65535, 65535, 65535, 65535));
        send_reading(make_reading(65535, 0, 0, 1));
        send_reading(make_reading(100, 100, 100, 256));
        send_reading(make_reading(165, 15, 15, 256));
        send_reading(make_reading(165, 165, 15, 256));
        send_reading(make_reading(15, 165, 15, 256));
        send_reading(make_reading(15, 165, 165, 256));
        send_reading(make_reading(15, 15, 165, 256));
        send_reading(make_reading(165, 15, 165, 256));
        send_reading(make_reading(165, 100, 15, 256));
        send_reading(make_reading(165, 15, 60, 256));
        send_reading(make_reading(120, 40, 40, 256));
        send_reading(make_reading(40, 40, 120, 256));
        send_reading(make_reading(40, 130, 40, 256));
        send_reading(make_reading(160, 150, 140, 256));
        send_reading(make_reading(30, 20, 16, 256));
        send_reading(make_reading(16'hAAAA, 16'h5555, 16'hFFFF, 16'h8000));
        send_reading(make_reading(16'h5555, 16'hAAAA, 16'h0001, 16'h7FFF));
        drain_pipeline();

        // Bounds not ascending, extreme thresholds
        set_config(200, 200, 0, 0, 100);
        send_reading(make_reading(300, 100, 50, 256));
        send_reading(make_reading(0, 65535, 0, 1));
        drain_pipeline();

        random_phase(250, 165);
        drain_pipeline();

        set_config(0, 65535, 100, 100, 0);
        random_phase(100, 65535);
        drain_pipeline();

        set_config(0, 256, 10, 20, 90);
        random_phase(250, 256);
        drain_pipeline();

        // Receiver holds off long while readings keep coming
        set_config(15, 165, 15, 35, 85);
        long_hold = 1'b1;
        random_phase(200, 165);
        drain_pipeline();

        set_config(65535, 0, 127, 127, 127);
        random_phase(30, 165);
        drain_pipeline();

        set_config(50, 51, 5, 10, 95);
        quiet_tail = 1'b1;
        random_phase(200, 60);
        drain_pipeline();

        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
